@@ sv/airborne_height_hold_smoother_assert.svh @@
// Assertion macros for the port-level checker
`ifndef AIRBORNE_HEIGHT_HOLD_SMOOTHER_ASSERT_SVH
`define AIRBORNE_HEIGHT_HOLD_SMOOTHER_ASSERT_SVH

// same-cycle implication
`define AHHS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define AHHS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/ahhs_pkg.sv @@
// Shared types, constants and table functions of the height hold smoother
package ahhs_pkg;

    localparam int          EXP_TABLE_BITS_DEF = 8;
    localparam logic [23:0] RATE_MAX           = 24'd12271616;
    localparam logic [32:0] DONE_BAND          = 33'd656;
    localparam logic [30:0] ONE30              = 31'h4000_0000;

    typedef enum logic [1:0] {
        MODE_NONE    = 2'd0,
        MODE_HOLD    = 2'd1,
        MODE_ASSIST  = 2'd2,
        MODE_RECOVER = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        REG_ENABLE       = 3'd0,
        REG_RATE_REC_TGT = 3'd1,
        REG_RATE_REC_CAM = 3'd2,
        REG_RATE_AST_TGT = 3'd3,
        REG_RATE_AST_CAM = 3'd4,
        REG_DROP_THR     = 3'd5,
        REG_DROP_HYST    = 3'd6
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_MUL_X,
        ST_MUL_F,
        ST_MUL_E,
        ST_MUL_S,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic latch;
        logic decide;
        logic mul_x;
        logic mul_f;
        logic mul_e;
        logic mul_s;
        logic chan;     // 0 target, 1 camera
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic need_approach;
        logic out_busy;
    } status_t;

    typedef struct packed {
        logic        enable;
        logic [23:0] rate_rec_tgt;
        logic [23:0] rate_rec_cam;
        logic [23:0] rate_ast_tgt;
        logic [23:0] rate_ast_cam;
        logic [30:0] drop_thr;
        logic [30:0] drop_hyst;
    } cfg_t;

    // exp(-i / 2^tb) in Q1.30, truncated Taylor series
    function automatic logic [30:0] frac_entry(int i, int tb);
        logic [63:0] y;
        logic [63:0] term;
        longint      sum;
        y    = 64'(i) << (30 - tb);
        term = 64'd1 << 30;
        sum  = longint'(64'd1 << 30);
        for (int n = 1; n <= 24; n++)
        begin
            term = ((term * y) >> 30) / 64'(n);
            if ((n & 1) == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        if (sum > longint'(64'd1 << 30))
            sum = longint'(64'd1 << 30);
        return sum[30:0];
    endfunction

    // exp(-n) in Q1.30 by repeated rounded products
    function automatic logic [30:0] int_entry(int n, int tb);
        logic [63:0] p;
        logic [63:0] last;
        last = 64'(frac_entry(1 << tb, tb));
        p    = 64'd1 << 30;
        for (int j = 0; j < n; j++)
        begin
            p = (p * last + (64'd1 << 29)) >> 30;
        end
        return p[30:0];
    endfunction

endpackage

@@ sv/ahhs_in_if.sv @@
// Input item channel
interface ahhs_in_if;
    logic               valid;
    logic               ready;
    logic               operation;
    logic               body_present;
    logic               grounded;
    logic signed [31:0] vertical_velocity;
    logic [15:0]        time_step;
    logic signed [31:0] desired_camera_y;
    logic signed [31:0] desired_target_y;

    modport source (output valid, operation, body_present, grounded, vertical_velocity,
                    time_step, desired_camera_y, desired_target_y, input ready);
    modport sink   (input valid, operation, body_present, grounded, vertical_velocity,
                    time_step, desired_camera_y, desired_target_y, output ready);
endinterface

@@ sv/ahhs_out_if.sv @@
// Result item channel
interface ahhs_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] camera_y;
    logic signed [31:0] target_y;
    logic [1:0]         mode_now;

    modport source (output valid, camera_y, target_y, mode_now, input ready);
    modport sink   (input valid, camera_y, target_y, mode_now, output ready);
endinterface

@@ sv/ahhs_cfg_if.sv @@
// Configuration write channel
interface ahhs_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [30:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/ahhs_cfg.sv @@
// Configuration register file
module ahhs_cfg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_valid,
    input  logic [2:0]         wr_index,
    input  logic [30:0]        wr_data,
    output logic               wr_ready,
    output ahhs_pkg::cfg_t     cfg
);

    ahhs_pkg::cfg_t cfg_reg;
    ahhs_pkg::cfg_t cfg_next;

    assign wr_ready = 1'b1;
    assign cfg      = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_valid)
        begin
            case (ahhs_pkg::reg_idx_t'(wr_index))
                ahhs_pkg::REG_ENABLE:       cfg_next.enable       = wr_data[0];
                ahhs_pkg::REG_RATE_REC_TGT: cfg_next.rate_rec_tgt = wr_data[23:0];
                ahhs_pkg::REG_RATE_REC_CAM: cfg_next.rate_rec_cam = wr_data[23:0];
                ahhs_pkg::REG_RATE_AST_TGT: cfg_next.rate_ast_tgt = wr_data[23:0];
                ahhs_pkg::REG_RATE_AST_CAM: cfg_next.rate_ast_cam = wr_data[23:0];
                ahhs_pkg::REG_DROP_THR:     cfg_next.drop_thr     = wr_data;
                ahhs_pkg::REG_DROP_HYST:    cfg_next.drop_hyst    = wr_data;
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable       <= 1'b1;
            cfg_reg.rate_rec_tgt <= 24'd4096;
            cfg_reg.rate_rec_cam <= 24'd4096;
            cfg_reg.rate_ast_tgt <= 24'd4096;
            cfg_reg.rate_ast_cam <= 24'd4096;
            cfg_reg.drop_thr     <= '0;
            cfg_reg.drop_hyst    <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ sv/ahhs_ctrl.sv @@
// Sequencing state machine
module ahhs_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  ahhs_pkg::status_t   status,
    output ahhs_pkg::cmd_t      cmd
);

    ahhs_pkg::state_t state_reg;
    ahhs_pkg::state_t state_next;
    logic             chan_reg;
    logic             chan_next;

    always_comb
    begin
        state_next = state_reg;
        chan_next  = chan_reg;
        case (state_reg)
            ahhs_pkg::ST_IDLE:
            begin
                if (in_valid)
                    state_next = ahhs_pkg::ST_DECIDE;
            end
            ahhs_pkg::ST_DECIDE:
            begin
                chan_next  = 1'b0;
                state_next = status.need_approach ? ahhs_pkg::ST_MUL_X : ahhs_pkg::ST_FINISH;
            end
            ahhs_pkg::ST_MUL_X: state_next = ahhs_pkg::ST_MUL_F;
            ahhs_pkg::ST_MUL_F: state_next = ahhs_pkg::ST_MUL_E;
            ahhs_pkg::ST_MUL_E: state_next = ahhs_pkg::ST_MUL_S;
            ahhs_pkg::ST_MUL_S:
            begin
                chan_next  = ~chan_reg;
                state_next = chan_reg ? ahhs_pkg::ST_FINISH : ahhs_pkg::ST_MUL_X;
            end
            ahhs_pkg::ST_FINISH:
            begin
                if (!status.out_busy)
                    state_next = ahhs_pkg::ST_IDLE;
            end
            default: state_next = ahhs_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready   = (state_reg == ahhs_pkg::ST_IDLE);
        cmd        = '0;
        cmd.latch  = in_valid && (state_reg == ahhs_pkg::ST_IDLE);
        cmd.decide = (state_reg == ahhs_pkg::ST_DECIDE);
        cmd.mul_x  = (state_reg == ahhs_pkg::ST_MUL_X);
        cmd.mul_f  = (state_reg == ahhs_pkg::ST_MUL_F);
        cmd.mul_e  = (state_reg == ahhs_pkg::ST_MUL_E);
        cmd.mul_s  = (state_reg == ahhs_pkg::ST_MUL_S);
        cmd.chan   = chan_reg;
        cmd.finish = (state_reg == ahhs_pkg::ST_FINISH) && !status.out_busy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ahhs_pkg::ST_IDLE;
            chan_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            chan_reg  <= chan_next;
        end
    end

endmodule

@@ sv/ahhs_dp.sv @@
// Datapath: held heights, mode logic, exponential approach unit, result register
module ahhs_dp #(
    parameter int EXP_TABLE_BITS = ahhs_pkg::EXP_TABLE_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ahhs_pkg::cfg_t      cfg,
    input  ahhs_pkg::cmd_t      cmd,
    output ahhs_pkg::status_t   status,
    input  logic                in_operation,
    input  logic                in_body_present,
    input  logic                in_grounded,
    input  logic signed [31:0]  in_vertical_velocity,
    input  logic [15:0]         in_time_step,
    input  logic signed [31:0]  in_desired_camera_y,
    input  logic signed [31:0]  in_desired_target_y,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  out_camera_y,
    output logic signed [31:0]  out_target_y,
    output logic [1:0]          out_mode_now
);

    localparam int FRAC_SIZE  = (1 << EXP_TABLE_BITS) + 1;
    localparam int FRAC_SHIFT = 28 - EXP_TABLE_BITS;

    logic [30:0] frac_tab [FRAC_SIZE];
    logic [30:0] int_tab  [16];

    for (genvar gi = 0; gi < FRAC_SIZE; gi++)
    begin : g_frac
        assign frac_tab[gi] = ahhs_pkg::frac_entry(gi, EXP_TABLE_BITS);
    end
    for (genvar gn = 0; gn < 16; gn++)
    begin : g_int
        assign int_tab[gn] = ahhs_pkg::int_entry(gn, EXP_TABLE_BITS);
    end

    // latched item
    logic               op_reg;
    logic               body_reg;
    logic               gnd_reg;
    logic               vneg_reg;
    logic [15:0]        dt_reg;
    logic signed [31:0] wc_reg;
    logic signed [31:0] wt_reg;

    // block state
    logic signed [31:0] hc_reg;
    logic signed [31:0] ht_reg;
    ahhs_pkg::mode_t    mode_reg;
    logic               wg_reg;
    logic               assist_reg;
    logic               active_reg;
    logic               pass_reg;

    // approach unit
    logic [39:0]        x_reg;
    logic [3:0]         n_reg;
    logic               big_reg;
    logic [30:0]        ef_reg;
    logic [30:0]        alpha_reg;

    // result register
    logic               out_valid_reg;
    logic signed [31:0] out_cam_reg;
    logic signed [31:0] out_tgt_reg;
    ahhs_pkg::mode_t    out_mode_reg;

    // mode decision
    logic               d_active;
    ahhs_pkg::mode_t    d_mode;
    logic               d_assist;
    logic signed [31:0] d_hc;
    logic signed [31:0] d_ht;
    logic signed [32:0] d_drop;
    logic signed [32:0] d_thr;
    logic signed [32:0] d_lim;
    logic               d_appr;

    always_comb
    begin
        d_active = !op_reg && cfg.enable && body_reg;
        d_mode   = mode_reg;
        d_assist = assist_reg;
        d_hc     = hc_reg;
        d_ht     = ht_reg;
        if (wg_reg && !gnd_reg)
        begin
            d_hc     = wc_reg;
            d_ht     = wt_reg;
            d_mode   = ahhs_pkg::MODE_HOLD;
            d_assist = 1'b0;
        end
        else if (!wg_reg && gnd_reg)
        begin
            d_mode   = ahhs_pkg::MODE_RECOVER;
            d_assist = 1'b0;
        end
        if (!gnd_reg)
        begin
            if (vneg_reg)
            begin
                if (d_mode == ahhs_pkg::MODE_HOLD)
                    d_mode = ahhs_pkg::MODE_ASSIST;
            end
            else
            begin
                d_mode = ahhs_pkg::MODE_HOLD;
            end
        end
        d_drop = {d_ht[31], d_ht} - {wt_reg[31], wt_reg};
        d_thr  = $signed({2'b00, cfg.drop_thr});
        d_lim  = d_thr - $signed({2'b00, cfg.drop_hyst});
        if (d_mode == ahhs_pkg::MODE_ASSIST)
        begin
            if (!d_assist)
            begin
                if (d_drop > d_thr)
                    d_assist = 1'b1;
            end
            else if (d_drop < d_lim)
            begin
                d_assist = 1'b0;
            end
        end
        d_appr = d_active && ((d_mode == ahhs_pkg::MODE_RECOVER) ||
                              ((d_mode == ahhs_pkg::MODE_ASSIST) && d_assist));
    end

    assign status.need_approach = d_appr;
    assign status.out_busy      = out_valid_reg && !out_ready;

    // approach arithmetic
    logic [23:0]              a_rate;
    logic [23:0]              a_k;
    logic [39:0]              a_x;
    logic [EXP_TABLE_BITS:0]  a_fi;
    logic [EXP_TABLE_BITS:0]  a_fi1;
    logic [FRAC_SHIFT-1:0]    a_rem;
    logic [30:0]              a_fa;
    logic [30:0]              a_fb;
    logic [30:0]              a_diff;
    logic [30+FRAC_SHIFT:0]   a_prod;
    logic [30:0]              a_ef;
    logic [61:0]              a_pe;
    logic [31:0]              a_e;
    logic [30:0]              a_alpha;
    logic signed [31:0]       a_cur;
    logic signed [31:0]       a_want;
    logic signed [32:0]       a_d;
    logic [32:0]              a_mag;
    logic [63:0]              a_ps;
    logic [31:0]              a_step;
    logic signed [31:0]       a_new;

    always_comb
    begin
        if (mode_reg == ahhs_pkg::MODE_RECOVER)
            a_rate = cmd.chan ? cfg.rate_rec_cam : cfg.rate_rec_tgt;
        else
            a_rate = cmd.chan ? cfg.rate_ast_cam : cfg.rate_ast_tgt;
        a_k = (a_rate > ahhs_pkg::RATE_MAX) ? ahhs_pkg::RATE_MAX : a_rate;
        a_x = {16'b0, a_k} * {24'b0, dt_reg};

        a_fi   = {1'b0, x_reg[27:FRAC_SHIFT]};
        a_fi1  = a_fi + 1'b1;
        a_rem  = x_reg[FRAC_SHIFT-1:0];
        a_fa   = frac_tab[a_fi];
        a_fb   = frac_tab[a_fi1];
        a_diff = (a_fa > a_fb) ? (a_fa - a_fb) : '0;
        a_prod = (31 + FRAC_SHIFT)'(a_diff) * (31 + FRAC_SHIFT)'(a_rem);
        a_ef   = a_fa - a_prod[30+FRAC_SHIFT:FRAC_SHIFT];

        a_pe    = 62'(int_tab[n_reg]) * 62'(ef_reg);
        a_e     = a_pe[61:30];
        if (big_reg)
            a_alpha = ahhs_pkg::ONE30;
        else if (a_e > {1'b0, ahhs_pkg::ONE30})
            a_alpha = '0;
        else
            a_alpha = ahhs_pkg::ONE30 - a_e[30:0];

        a_cur  = cmd.chan ? hc_reg : ht_reg;
        a_want = cmd.chan ? wc_reg : wt_reg;
        a_d    = {a_want[31], a_want} - {a_cur[31], a_cur};
        a_mag  = a_d[32] ? 33'(-a_d) : 33'(a_d);
        a_ps   = 64'(a_mag) * 64'(alpha_reg) + (64'd1 << 29);
        a_step = a_ps[61:30];
        a_new  = a_d[32] ? (a_cur - $signed(a_step)) : (a_cur + $signed(a_step));
    end

    // done band check and final mode
    logic signed [32:0] f_dt;
    logic signed [32:0] f_dc;
    logic [32:0]        f_mt;
    logic [32:0]        f_mc;
    ahhs_pkg::mode_t    f_mode;

    always_comb
    begin
        f_dt = {ht_reg[31], ht_reg} - {wt_reg[31], wt_reg};
        f_dc = {hc_reg[31], hc_reg} - {wc_reg[31], wc_reg};
        f_mt = f_dt[32] ? 33'(-f_dt) : 33'(f_dt);
        f_mc = f_dc[32] ? 33'(-f_dc) : 33'(f_dc);
        f_mode = mode_reg;
        if (active_reg && (mode_reg == ahhs_pkg::MODE_RECOVER) &&
            (f_mt < ahhs_pkg::DONE_BAND) && (f_mc < ahhs_pkg::DONE_BAND))
            f_mode = ahhs_pkg::MODE_NONE;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg   <= in_operation;
            body_reg <= in_body_present;
            gnd_reg  <= in_grounded;
            vneg_reg <= in_vertical_velocity[31];
            dt_reg   <= in_time_step;
            wc_reg   <= in_desired_camera_y;
            wt_reg   <= in_desired_target_y;
        end
        if (cmd.mul_x)
            x_reg <= a_x;
        if (cmd.mul_f)
        begin
            ef_reg  <= a_ef;
            n_reg   <= x_reg[31:28];
            big_reg <= |x_reg[39:32];
        end
        if (cmd.mul_e)
            alpha_reg <= a_alpha;
        if (cmd.finish)
        begin
            out_cam_reg  <= pass_reg ? wc_reg : hc_reg;
            out_tgt_reg  <= pass_reg ? wt_reg : ht_reg;
            out_mode_reg <= f_mode;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hc_reg        <= '0;
            ht_reg        <= '0;
            mode_reg      <= ahhs_pkg::MODE_NONE;
            wg_reg        <= 1'b1;
            assist_reg    <= 1'b0;
            active_reg    <= 1'b0;
            pass_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.decide)
            begin
                if (op_reg)
                begin
                    hc_reg     <= wc_reg;
                    ht_reg     <= wt_reg;
                    wg_reg     <= 1'b1;
                    mode_reg   <= ahhs_pkg::MODE_NONE;
                    assist_reg <= 1'b0;
                    active_reg <= 1'b0;
                    pass_reg   <= 1'b1;
                end
                else if (d_active)
                begin
                    hc_reg     <= d_hc;
                    ht_reg     <= d_ht;
                    wg_reg     <= gnd_reg;
                    mode_reg   <= d_mode;
                    assist_reg <= d_assist;
                    active_reg <= 1'b1;
                    pass_reg   <= (d_mode == ahhs_pkg::MODE_NONE);
                end
                else
                begin
                    active_reg <= 1'b0;
                    pass_reg   <= 1'b1;
                end
            end
            if (cmd.mul_s)
            begin
                if (cmd.chan)
                    hc_reg <= a_new;
                else
                    ht_reg <= a_new;
            end
            if (cmd.finish)
                mode_reg <= f_mode;
            if (cmd.finish)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_camera_y = out_cam_reg;
    assign out_target_y = out_tgt_reg;
    assign out_mode_now = out_mode_reg;

endmodule

@@ sv/airborne_height_hold_smoother.sv @@
// Top level of the airborne height hold smoother
//
//   channel    role     transfer carries
//   in_item    sink     operation, flags, velocity, time step, desired heights
//   out_item   source   camera_y, target_y, mode_now
//   cfg        sink     register index, write data
//
// An item passes through idle, decide and finish; when both heights approach,
// four steps per height through the shared approach unit (rate x time step,
// table interpolation, exponent product, height update) run in sequence before finish.
// Reset is asynchronous, active low; no clearing pass is needed.
// A finished result waits in the output register; the next item is taken
// meanwhile and stalls only in its last cycle if the result is still untaken.
module airborne_height_hold_smoother #(
    parameter int EXP_TABLE_BITS = ahhs_pkg::EXP_TABLE_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    ahhs_in_if.sink    in_item,
    ahhs_out_if.source out_item,
    ahhs_cfg_if.sink   cfg
);

    ahhs_pkg::cfg_t    cfg_q;
    ahhs_pkg::cmd_t    cmd;
    ahhs_pkg::status_t status;

    ahhs_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .wr_ready (cfg.ready),
        .cfg      (cfg_q)
    );

    ahhs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_item.valid),
        .in_ready (in_item.ready),
        .status   (status),
        .cmd      (cmd)
    );

    ahhs_dp #(
        .EXP_TABLE_BITS (EXP_TABLE_BITS)
    ) u_dp (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cfg                  (cfg_q),
        .cmd                  (cmd),
        .status               (status),
        .in_operation         (in_item.operation),
        .in_body_present      (in_item.body_present),
        .in_grounded          (in_item.grounded),
        .in_vertical_velocity (in_item.vertical_velocity),
        .in_time_step         (in_item.time_step),
        .in_desired_camera_y  (in_item.desired_camera_y),
        .in_desired_target_y  (in_item.desired_target_y),
        .out_valid            (out_item.valid),
        .out_ready            (out_item.ready),
        .out_camera_y         (out_item.camera_y),
        .out_target_y         (out_item.target_y),
        .out_mode_now         (out_item.mode_now)
    );

endmodule

@@ sv/ahhs_check.sv @@
// Port-level checker for the height hold smoother, bound to the top level
`include "airborne_height_hold_smoother_assert.svh"

module ahhs_check (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_camera_y,
    input logic [31:0] out_target_y,
    input logic [1:0]  out_mode_now
);

    logic        stall;
    logic        in_xfer;
    logic [65:0] out_word;

    assign stall    = out_valid && !out_ready;
    assign in_xfer  = in_valid && in_ready;
    assign out_word = {out_camera_y, out_target_y, out_mode_now};

    `AHHS_ASSERT_NEXT(a_out_hold, clk, rst_n, stall, out_valid, "result dropped while stalled")
    `AHHS_ASSERT_NEXT(a_out_stable, clk, rst_n, stall, $stable(out_word), "stalled result changed")
    `AHHS_ASSERT_NEXT(a_no_early_result, clk, rst_n, in_xfer, !$rose(out_valid), "early result")
    `AHHS_ASSERT_NOW(a_result_busy, clk, rst_n, $rose(out_valid), $past(!in_ready), "idle result")

endmodule

bind airborne_height_hold_smoother ahhs_check u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_item.valid),
    .in_ready     (in_item.ready),
    .out_valid    (out_item.valid),
    .out_ready    (out_item.ready),
    .out_camera_y (out_item.camera_y),
    .out_target_y (out_item.target_y),
    .out_mode_now (out_item.mode_now)
);

@@ verif/airborne_height_hold_smoother_tb.sv @@
// Self-checking testbench for the airborne height hold smoother
`timescale 1ns / 1ps

module airborne_height_hold_smoother_tb;

    localparam int          TBITS     = ahhs_pkg::EXP_TABLE_BITS_DEF;
    localparam int          FSIZE     = (1 << TBITS) + 1;
    localparam int          FSH       = 28 - TBITS;
    localparam longint      UNITY     = 64'd1 << 30;
    localparam int          WD_LIMIT  = 20000;
    localparam logic [23:0] RATE_OVER = 24'hFF_FFFF;

    typedef struct {
        bit                 op;
        bit                 body;
        bit                 gnd;
        logic signed [31:0] vel;
        logic [15:0]        dt;
        logic signed [31:0] cam;
        logic signed [31:0] tgt;
        bit                 typed;
        logic signed [31:0] e_cam;
        logic signed [31:0] e_tgt;
        logic [1:0]         e_mode;
    } row_t;

    typedef struct {
        logic signed [31:0] cam;
        logic signed [31:0] tgt;
        logic [1:0]         mode;
    } heights_t;

    logic clk;
    logic rst_n;

    ahhs_in_if  ifc_in ();
    ahhs_out_if ifc_out ();
    ahhs_cfg_if ifc_cfg ();

    airborne_height_hold_smoother u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (ifc_in),
        .out_item (ifc_out),
        .cfg      (ifc_cfg)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // predictor state
    longint unsigned    decay_frac [FSIZE];
    longint unsigned    decay_int [16];
    ahhs_pkg::cfg_t     regs;
    logic signed [31:0] held_cam;
    logic signed [31:0] held_tgt;
    bit                 was_gnd;
    ahhs_pkg::mode_t    mode;
    bit                 assist;

    heights_t           heights_q [$];
    row_t               typed_q [$];
    int                 fails = 0;
    int                 gap_pct;
    int                 stall_pct;
    int                 quiet_cycles = 0;

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        fails++;
    endtask

    function automatic void build_decay();
        longint unsigned y;
        longint unsigned term;
        longint          sum;
        for (int i = 0; i < FSIZE; i++)
        begin
            y    = longint'(i) << (30 - TBITS);
            term = UNITY;
            sum  = UNITY;
            for (int n = 1; n <= 24; n++)
            begin
                term = ((term * y) >> 30) / n;
                sum  = (n % 2 == 1) ? sum - longint'(term) : sum + longint'(term);
            end
            if (sum < 0)
                sum = 0;
            if (sum > UNITY)
                sum = UNITY;
            decay_frac[i] = sum;
        end
        decay_int[0] = UNITY;
        for (int n = 1; n < 16; n++)
            decay_int[n] = (decay_int[n-1] * decay_frac[FSIZE-1] + (64'd1 << 29)) >> 30;
    endfunction

    function automatic longint unsigned blend_of(logic [23:0] rate, logic [15:0] dt);
        longint unsigned k;
        longint unsigned x;
        longint unsigned n;
        longint unsigned fx;
        longint unsigned f;
        longint unsigned rem;
        longint unsigned a;
        longint unsigned b;
        longint unsigned diff;
        longint unsigned ef;
        longint unsigned e;
        k = (rate > ahhs_pkg::RATE_MAX) ? ahhs_pkg::RATE_MAX : rate;
        x = k * dt;
        n = x >> 28;
        if (n >= 16)
            return UNITY;
        fx   = x & ((64'd1 << 28) - 1);
        f    = fx >> FSH;
        rem  = fx & ((64'd1 << FSH) - 1);
        a    = decay_frac[f];
        b    = decay_frac[f+1];
        diff = (a > b) ? a - b : 0;
        ef   = a - ((diff * rem) >> FSH);
        e    = (decay_int[n] * ef) >> 30;
        return (e > UNITY) ? 0 : UNITY - e;
    endfunction

    function automatic logic signed [31:0] ease(logic signed [31:0] cur, logic signed [31:0] want,
                                                logic [23:0] rate, logic [15:0] dt);
        longint          d;
        longint unsigned mag;
        longint unsigned stp;
        longint          r;
        d   = longint'(want) - longint'(cur);
        mag = (d < 0) ? -d : d;
        stp = (mag * blend_of(rate, dt) + (64'd1 << 29)) >> 30;
        r   = (d < 0) ? longint'(cur) - longint'(stp) : longint'(cur) + longint'(stp);
        return r[31:0];
    endfunction

    function automatic bit settled(logic signed [31:0] a, logic signed [31:0] b);
        longint d;
        d = longint'(a) - longint'(b);
        if (d < 0)
            d = -d;
        return d < 656;
    endfunction

    function automatic heights_t next_heights(row_t r);
        heights_t h;
        longint   drop;
        h.cam = r.cam;
        h.tgt = r.tgt;
        if (r.op)
        begin
            held_cam = r.cam;
            held_tgt = r.tgt;
            was_gnd  = 1'b1;
            mode     = ahhs_pkg::MODE_NONE;
            assist   = 1'b0;
        end
        else if (regs.enable && r.body)
        begin
            if (was_gnd && !r.gnd)
            begin
                held_cam = r.cam;
                held_tgt = r.tgt;
                mode     = ahhs_pkg::MODE_HOLD;
                assist   = 1'b0;
            end
            else if (!was_gnd && r.gnd)
            begin
                mode   = ahhs_pkg::MODE_RECOVER;
                assist = 1'b0;
            end
            if (!r.gnd)
            begin
                if (r.vel < 0)
                begin
                    if (mode == ahhs_pkg::MODE_HOLD)
                        mode = ahhs_pkg::MODE_ASSIST;
                end
                else
                    mode = ahhs_pkg::MODE_HOLD;
            end
            if (mode == ahhs_pkg::MODE_HOLD)
            begin
                h.cam = held_cam;
                h.tgt = held_tgt;
            end
            else if (mode == ahhs_pkg::MODE_ASSIST)
            begin
                drop = longint'(held_tgt) - longint'(r.tgt);
                if (!assist)
                begin
                    if (drop > longint'(regs.drop_thr))
                        assist = 1'b1;
                end
                else if (drop < longint'(regs.drop_thr) - longint'(regs.drop_hyst))
                    assist = 1'b0;
                if (assist)
                begin
                    held_tgt = ease(held_tgt, r.tgt, regs.rate_ast_tgt, r.dt);
                    held_cam = ease(held_cam, r.cam, regs.rate_ast_cam, r.dt);
                end
                h.cam = held_cam;
                h.tgt = held_tgt;
            end
            else if (mode == ahhs_pkg::MODE_RECOVER)
            begin
                held_tgt = ease(held_tgt, r.tgt, regs.rate_rec_tgt, r.dt);
                held_cam = ease(held_cam, r.cam, regs.rate_rec_cam, r.dt);
                h.cam = held_cam;
                h.tgt = held_tgt;
                if (settled(held_tgt, r.tgt) && settled(held_cam, r.cam))
                    mode = ahhs_pkg::MODE_NONE;
            end
            was_gnd = r.gnd;
        end
        h.mode = mode;
        return h;
    endfunction

    // checking and prediction, both sampled at the edge
    always @(posedge clk)
    begin
        heights_t want;
        heights_t got;
        row_t     r;
        if (ifc_out.valid && ifc_out.ready)
        begin
            got.cam  = ifc_out.camera_y;
            got.tgt  = ifc_out.target_y;
            got.mode = ifc_out.mode_now;
            if (heights_q.size() == 0)
                report("unexpected result", got.cam, 0);
            else
            begin
                want = heights_q.pop_front();
                if (got.cam !== want.cam)
                    report("camera_y", got.cam, want.cam);
                if (got.tgt !== want.tgt)
                    report("target_y", got.tgt, want.tgt);
                if (got.mode !== want.mode)
                    report("mode_now", got.mode, want.mode);
            end
        end
        if (ifc_cfg.valid && ifc_cfg.ready)
        begin
            case (ahhs_pkg::reg_idx_t'(ifc_cfg.index))
                ahhs_pkg::REG_ENABLE:       regs.enable       = ifc_cfg.data[0];
                ahhs_pkg::REG_RATE_REC_TGT: regs.rate_rec_tgt = ifc_cfg.data[23:0];
                ahhs_pkg::REG_RATE_REC_CAM: regs.rate_rec_cam = ifc_cfg.data[23:0];
                ahhs_pkg::REG_RATE_AST_TGT: regs.rate_ast_tgt = ifc_cfg.data[23:0];
                ahhs_pkg::REG_RATE_AST_CAM: regs.rate_ast_cam = ifc_cfg.data[23:0];
                ahhs_pkg::REG_DROP_THR:     regs.drop_thr     = ifc_cfg.data;
                ahhs_pkg::REG_DROP_HYST:    regs.drop_hyst    = ifc_cfg.data;
                default:                    ;
            endcase
        end
        if (ifc_in.valid && ifc_in.ready)
        begin
            r      = typed_q.pop_front();
            r.op   = ifc_in.operation;
            r.body = ifc_in.body_present;
            r.gnd  = ifc_in.grounded;
            r.vel  = ifc_in.vertical_velocity;
            r.dt   = ifc_in.time_step;
            r.cam  = ifc_in.desired_camera_y;
            r.tgt  = ifc_in.desired_target_y;
            want   = next_heights(r);
            if (r.typed)
            begin
                want.cam  = r.e_cam;
                want.tgt  = r.e_tgt;
                want.mode = r.e_mode;
            end
            heights_q.push_back(want);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            ifc_out.ready <= 1'b0;
        else
            ifc_out.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if ((ifc_in.valid && ifc_in.ready) || (ifc_out.valid && ifc_out.ready) ||
            (ifc_cfg.valid && ifc_cfg.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WD_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_row(row_t r);
        int gap;
        gap = 0;
        while ($urandom_range(99) < gap_pct && gap < 20)
            gap++;
        if (gap > 0)
        begin
            ifc_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        typed_q.push_back(r);
        ifc_in.valid             <= 1'b1;
        ifc_in.operation         <= r.op;
        ifc_in.body_present      <= r.body;
        ifc_in.grounded          <= r.gnd;
        ifc_in.vertical_velocity <= r.vel;
        ifc_in.time_step         <= r.dt;
        ifc_in.desired_camera_y  <= r.cam;
        ifc_in.desired_target_y  <= r.tgt;
        do
            @(posedge clk);
        while (!ifc_in.ready);
    endtask

    task automatic send_tick(bit op, bit body, bit gnd, logic signed [31:0] vel,
                             logic [15:0] dt, logic signed [31:0] cam, logic signed [31:0] tgt);
        row_t r;
        r       = '{default: 0};
        r.op    = op;
        r.body  = body;
        r.gnd   = gnd;
        r.vel   = vel;
        r.dt    = dt;
        r.cam   = cam;
        r.tgt   = tgt;
        send_row(r);
    endtask

    // items still to be accepted or still awaiting their result
    task automatic drain();
        ifc_in.valid <= 1'b0;
        while (typed_q.size() != 0 || heights_q.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_regs(logic [30:0] vals [7]);
        for (int i = 0; i < 7; i++)
        begin
            ifc_cfg.valid <= 1'b1;
            ifc_cfg.index <= 3'(i);
            ifc_cfg.data  <= vals[i];
            do
                @(posedge clk);
            while (!ifc_cfg.ready);
        end
        ifc_cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [15:0] pick_dt();
        return ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(4000));
    endfunction

    // grounded, take-off, climb, fall, landing and recovery with random content
    task automatic fly(ref int sent);
        logic signed [31:0] base_c;
        logic signed [31:0] base_t;
        logic signed [31:0] c;
        logic signed [31:0] t;
        base_c = $signed($urandom_range(32'h0100_0000)) - 32'sh0080_0000;
        base_t = base_c - $signed($urandom_range(32'h0002_0000));
        c = base_c;
        t = base_t;
        repeat ($urandom_range(1, 3))
        begin
            send_tick(0, 1, 1, $signed($urandom), pick_dt(), c, t);
            sent++;
        end
        repeat ($urandom_range(0, 3))
        begin
            c = c + $signed($urandom_range(32'h4000));
            t = t + $signed($urandom_range(32'h4000));
            send_tick(0, 1, 0, $signed($urandom_range(32'h7FFF_FFFF)), pick_dt(), c, t);
            sent++;
        end
        repeat ($urandom_range(1, 6))
        begin
            c = c - $signed($urandom_range(32'h0002_0000));
            t = t - $signed($urandom_range(32'h0002_0000));
            send_tick(0, 1, 0, -$signed($urandom_range(1, 32'h7FFF_FFFF)), pick_dt(), c, t);
            sent++;
        end
        repeat ($urandom_range(2, 8))
        begin
            c = c + $signed($urandom_range(32'h100)) - 32'sh80;
            t = t + $signed($urandom_range(32'h100)) - 32'sh80;
            send_tick(0, 1, 1, 0, pick_dt(), c, t);
            sent++;
        end
    endtask

    task automatic noise(ref int sent);
        send_tick($urandom_range(9) == 0, $urandom_range(4) != 0, $urandom_range(1),
                  $signed($urandom), 16'($urandom), $signed($urandom), $signed($urandom));
        sent++;
    endtask

    row_t directed [15] = '{
        '{1, 1, 1, 0, 16'h0, 32'sh7FFF_FFFF, 32'sh8000_0000,
          1, 32'sh7FFF_FFFF, 32'sh8000_0000, ahhs_pkg::MODE_NONE},
        '{0, 0, 0, -1, 16'hFFFF, 32'sh100, -32'sh100, 1, 32'sh100, -32'sh100,
          ahhs_pkg::MODE_NONE},
        '{0, 1, 0, 32'sh7FFF_FFFF, 16'h1000, 32'sh5_0000, 32'sh3_0000,
          1, 32'sh5_0000, 32'sh3_0000, ahhs_pkg::MODE_HOLD},
        '{0, 1, 0, 0, 16'h1000, 32'sh6_0000, 32'sh4_0000,
          1, 32'sh5_0000, 32'sh3_0000, ahhs_pkg::MODE_HOLD},
        '{0, 1, 0, 32'sh8000_0000, 16'h8000, 32'sh1_0000, 0, 0, 0, 0, 0},
        '{0, 1, 0, -1, 16'h0, 32'sh1_0000, 0, 0, 0, 0, 0},
        '{0, 1, 0, -1, 16'hFFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0, 0, 0},
        '{0, 1, 0, -1, 16'h0001, 0, 32'sh7FFF_FFFF, 0, 0, 0, 0},
        '{0, 1, 1, 0, 16'hFFFF, 0, 0, 0, 0, 0, 0},
        '{0, 1, 1, 0, 16'hFFFF, 0, 0, 0, 0, 0, 0},
        '{0, 1, 1, 0, 16'hFFFF, 0, 0, 0, 0, 0, 0},
        '{0, 1, 1, 0, 16'hFFFF, 0, 0, 0, 0, 0, 0},
        '{0, 1, 1, 0, 16'hFFFF, 32'sh100, 32'sh100, 0, 0, 0, 0},
        '{1, 0, 0, -1, 16'hFFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
          1, 32'sh8000_0000, 32'sh7FFF_FFFF, ahhs_pkg::MODE_NONE},
        '{0, 0, 1, 0, 16'h0, 32'sh1234, -32'sh1234, 1, 32'sh1234, -32'sh1234,
          ahhs_pkg::MODE_NONE}
    };

    initial
    begin
        logic [30:0] vals [7];
        int          sent;
        rst_n                    = 1'b0;
        ifc_in.valid             = 1'b0;
        ifc_in.operation         = 1'b0;
        ifc_in.body_present      = 1'b0;
        ifc_in.grounded          = 1'b0;
        ifc_in.vertical_velocity = '0;
        ifc_in.time_step         = '0;
        ifc_in.desired_camera_y  = '0;
        ifc_in.desired_target_y  = '0;
        ifc_cfg.valid            = 1'b0;
        ifc_cfg.index            = '0;
        ifc_cfg.data             = '0;
        gap_pct                  = 35;
        stall_pct                = 65;
        sent                     = 0;
        build_decay();
        regs     = '{enable: 1'b1, rate_rec_tgt: 24'd4096, rate_rec_cam: 24'd4096,
                     rate_ast_tgt: 24'd4096, rate_ast_cam: 24'd4096, drop_thr: '0,
                     drop_hyst: '0};
        held_cam = '0;
        held_tgt = '0;
        was_gnd  = 1'b1;
        mode     = ahhs_pkg::MODE_NONE;
        assist   = 1'b0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_row(directed[i]);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: vals = '{1, 4096, 4096, 4096, 4096, 0, 0};
                1: vals = '{1, ahhs_pkg::RATE_MAX, RATE_OVER, 0, 1, 31'h7FFF_FFFF,
                            31'h7FFF_FFFF};
                2: vals = '{0, 31'($urandom_range(ahhs_pkg::RATE_MAX)),
                            31'($urandom_range(ahhs_pkg::RATE_MAX)),
                            31'($urandom_range(ahhs_pkg::RATE_MAX)),
                            31'($urandom_range(ahhs_pkg::RATE_MAX)), 0, 0};
                3: vals = '{1, 31'($urandom_range(ahhs_pkg::RATE_MAX)),
                            31'($urandom_range(ahhs_pkg::RATE_MAX)),
                            31'($urandom_range(ahhs_pkg::RATE_MAX)),
                            31'($urandom_range(ahhs_pkg::RATE_MAX)),
                            31'h8000, 31'h4000};
                4: vals = '{1, 0, 0, ahhs_pkg::RATE_MAX, ahhs_pkg::RATE_MAX, 0,
                            31'h7FFF_FFFF};
                default: vals = '{1, 31'($urandom), 31'($urandom), 31'($urandom),
                                  31'($urandom),
                                  31'($urandom_range(32'h0002_0000)),
                                  31'($urandom_range(32'h0001_0000))};
            endcase
            write_regs(vals);
            while (sent < 250 * (ph + 1))
            begin
                if (sent >= 500 && sent < 1000)
                begin
                    gap_pct   = 65;
                    stall_pct = 35;
                end
                else if (sent >= 1000)
                begin
                    gap_pct   = 0;
                    stall_pct = 0;
                end
                if ($urandom_range(99) < 80)
                    fly(sent);
                else
                    noise(sent);
            end
            drain();
        end

        drain();
        if (fails == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+sv
sv/ahhs_pkg.sv
sv/ahhs_in_if.sv
sv/ahhs_out_if.sv
sv/ahhs_cfg_if.sv
sv/ahhs_cfg.sv
sv/ahhs_ctrl.sv
sv/ahhs_dp.sv
sv/airborne_height_hold_smoother.sv
sv/ahhs_check.sv
verif/airborne_height_hold_smoother_tb.sv
